[design/mks_pkg.sv]
package mks_pkg;

    localparam int SENSE_ROWS   = 8;   // row sense lines on the input item
    localparam int COLUMN_LINES = 5;   // column drive lines on the result item
    localparam int KEY_W        = 7;
    localparam int CFG_W        = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd200;

    localparam int LEGEND_ROWS = 8;
    localparam int LEGEND_COLS = 5;

    // row-major ASCII legends
    localparam logic [KEY_W-1:0] KEY_LEGEND [LEGEND_ROWS*LEGEND_COLS] = '{
        7'h68, 7'h4D, 7'h4E, 7'h51, 7'h50,
        7'h67, 7'h45, 7'h46, 7'h47, 7'h48,
        7'h66, 7'h49, 7'h4A, 7'h4B, 7'h4C,
        7'h65, 7'h4D, 7'h28, 7'h29, 7'h43,
        7'h64, 7'h37, 7'h38, 7'h39, 7'h2A,
        7'h63, 7'h34, 7'h35, 7'h36, 7'h2D,
        7'h62, 7'h31, 7'h32, 7'h33, 7'h2B,
        7'h61, 7'h30, 7'h2E, 7'h53, 7'h3D
    };

    // positions outside the legend grid give code 0
    function automatic logic [KEY_W-1:0] legend_at(input logic [4:0] r, input logic [4:0] c);
        logic [7:0] idx;
        idx = 8'(r) * 8'(LEGEND_COLS) + 8'(c);
        if (int'(r) >= LEGEND_ROWS || int'(c) >= LEGEND_COLS) begin
            return '0;
        end
        return KEY_LEGEND[idx[5:0]];
    endfunction

endpackage

[design/mks_row_find.sv]
module mks_row_find #(
    parameter int ROW_COUNT = 8,
    parameter int RW        = $clog2(ROW_COUNT)
) (
    input  logic [mks_pkg::SENSE_ROWS-1:0] row_levels,
    input  logic [RW-1:0]                  resume_row,
    input  logic [RW-1:0]                  held_row,
    output logic                           found,
    output logic [RW-1:0]                  found_row,
    output logic                           held_pressed
);
    import mks_pkg::*;

    logic [ROW_COUNT+SENSE_ROWS-1:0] levels_ext;
    logic [ROW_COUNT-1:0]            pressed;

    // rows without a sense line read released
    assign levels_ext = {{ROW_COUNT{1'b1}}, row_levels};
    assign pressed    = ~levels_ext[ROW_COUNT-1:0];

    assign held_pressed = pressed[held_row];

    // lowest pressed row at or after resume_row
    always_comb begin
        found     = 1'b0;
        found_row = '0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            if (pressed[r] && r >= int'(resume_row)) begin
                found     = 1'b1;
                found_row = RW'(r);
            end
        end
    end

endmodule

[design/matrix_keypad_scanner_core.sv]
// Keypad matrix scanner with debounce, one scan tick per item.
// The result item is registered at the edge that accepts its tick.
// Throughput: one item per cycle while m_tready is high; the output register is refilled on the cycle it drains.
// Reset (aresetn low, synchronous): scan restarts at column 0, row 0, no key held,
// debounce_ticks returns to 200.
module matrix_keypad_scanner_core #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mks_pkg::CFG_W-1:0]    cfg_data,     // debounce_ticks
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,      // [7:0] row_levels
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,      // [4:0] column_drive, [11:5] key_code
    output logic                         m_tuser       // [0] sweep_done
);
    import mks_pkg::*;

    localparam int RW = $clog2(ROW_COUNT);
    localparam int CW = $clog2(COLUMN_COUNT);

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_DEBOUNCE,
        PH_RELEASE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [CW-1:0]           column_reg, column_next;
    logic [RW-1:0]           resume_reg, resume_next;
    logic [RW-1:0]           held_reg, held_next;
    logic [CFG_W-1:0]        count_reg, count_next;
    logic [CFG_W-1:0]        debounce_reg;
    logic [KEY_W-1:0]        sweep_key_reg, sweep_key_next;
    logic                    m_valid_reg;
    logic [COLUMN_LINES-1:0] drive_reg, drive_next;
    logic                    done_reg, done_next;
    logic [KEY_W-1:0]        code_reg, code_next;

    logic                    accept;
    logic                    found;
    logic [RW-1:0]           found_row;
    logic                    held_pressed;
    logic                    col_step;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = done_reg;
    assign m_tdata  = {4'b0, code_reg, drive_reg};

    mks_row_find #(
        .ROW_COUNT (ROW_COUNT),
        .RW        (RW)
    ) u_row_find (
        .row_levels   (s_tdata[SENSE_ROWS-1:0]),
        .resume_row   (resume_reg),
        .held_row     (held_reg),
        .found        (found),
        .found_row    (found_row),
        .held_pressed (held_pressed)
    );

    always_comb begin
        phase_next     = phase_reg;
        column_next    = column_reg;
        resume_next    = resume_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        sweep_key_next = sweep_key_reg;
        col_step       = 1'b0;
        done_next      = 1'b0;
        code_next      = '0;

        unique case (phase_reg)
            PH_DEBOUNCE: begin
                count_next = (count_reg != '0) ? count_reg - 1'b1 : '0;
                if (count_next == '0) begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (!held_pressed) begin
                    sweep_key_next = legend_at(5'(held_reg), 5'(column_reg));
                    phase_next     = PH_SCAN;
                    if (int'(held_reg) == ROW_COUNT - 1) begin
                        col_step = 1'b1;
                    end else begin
                        resume_next = held_reg + 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_SCAN;
                if (found) begin
                    held_next  = found_row;
                    count_next = debounce_reg;
                    phase_next = (debounce_reg == '0) ? PH_RELEASE : PH_DEBOUNCE;
                end else begin
                    col_step = 1'b1;
                end
            end
        endcase

        if (col_step) begin
            resume_next = '0;
            if (int'(column_reg) == COLUMN_COUNT - 1) begin
                column_next = '0;
                done_next   = 1'b1;
            end else begin
                column_next = column_reg + 1'b1;
            end
        end

        if (done_next) begin
            code_next      = sweep_key_next;
            sweep_key_next = '0;
        end

        // columns past the drive lines leave every line high
        if (int'(column_next) < COLUMN_LINES) begin
            drive_next = ~(COLUMN_LINES'(1) << column_next);
        end else begin
            drive_next = '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SCAN;
            column_reg    <= '0;
            resume_reg    <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            sweep_key_reg <= '0;
            debounce_reg  <= DEBOUNCE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                column_reg    <= column_next;
                resume_reg    <= resume_next;
                held_reg      <= held_next;
                count_reg     <= count_next;
                sweep_key_reg <= sweep_key_next;
                m_valid_reg   <= 1'b1;
                drive_reg     <= drive_next;
                done_reg      <= done_next;
                code_reg      <= code_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_code_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !done_reg |-> code_reg == '0)
        else $error("key code without sweep end");

    a_one_column_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $countones(~drive_reg) <= 1)
        else $error("more than one column driven low");

    a_debounce_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DEBOUNCE |-> count_reg != '0)
        else $error("debounce phase with zero count");

    a_resume_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(resume_reg) < ROW_COUNT && int'(column_reg) < COLUMN_COUNT)
        else $error("scan position out of range");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable(column_reg) && $stable(phase_reg))
        else $error("scan state moved while result stalled");
`endif

endmodule
